// ===== rtl/dlpe_pkg.sv =====
// shared types, constants and state codes for the line-program encoder
package dlpe_pkg;

	localparam int FILE_SLOTS_DEF = 16;

	localparam logic [1:0] OP_DEFINE = 2'd0;
	localparam logic [1:0] OP_LINE   = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_UNKNOWN_FILE = 3'd1;
	localparam logic [2:0] ST_BAD_RECORD   = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
	localparam logic [2:0] ST_NO_LINES     = 3'd4;

	localparam logic [7:0] DW_EXTENDED  = 8'h00;
	localparam logic [7:0] DW_COPY      = 8'h01;
	localparam logic [7:0] DW_ADV_PC    = 8'h02;
	localparam logic [7:0] DW_ADV_LINE  = 8'h03;
	localparam logic [7:0] DW_SET_FILE  = 8'h04;
	localparam logic [7:0] DW_SET_COL   = 8'h05;
	localparam logic [7:0] DW_EXT_LEN   = 8'h09;
	localparam logic [7:0] DW_END_SEQ   = 8'h01;
	localparam logic [7:0] DW_SET_ADDR  = 8'h02;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] file_id;
		logic [31:0] line_number;
		logic [31:0] column;
		logic [31:0] code_offset;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [2:0] status;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SEARCH_RD,
		S_SEARCH_CMP,
		S_PRE,
		S_FILE_OP,
		S_FILE_VAL,
		S_COL_OP,
		S_COL_VAL,
		S_LINE_OP,
		S_LINE_VAL,
		S_PC_OP,
		S_PC_VAL,
		S_COPY,
		S_END_PC_OP,
		S_END_PC_VAL,
		S_END_BYTES,
		S_ERR
	} state_t;

endpackage

// ===== rtl/dwarf_line_program_encoder.sv =====
// top level of the line-number program encoder: sequencer, leb128 shifter, file table
//
// one request is taken at a time; ready is low while its bytes go out. a define
// request is handled without leaving idle. a line record first searches the file
// table one entry at a time, through a read state and a compare state for each
// (the ram's registered read port), then sends one byte per cycle while the output
// is taken: 11 preamble bytes on the first record, then at most 2+6+6+6+1 bytes for
// the changed fields; each unchanged field still passes through its own sequencer
// state. end of sequence sends up to 9 bytes. every leb128 field goes through one
// shared 33-bit shift register that peels off seven bits per byte. errors give a
// single byte carrying the sticky status. a result waits in an output register
// until taken, and the sequencer holds while it is full and not drained.
module dwarf_line_program_encoder #(
	parameter int FILE_SLOTS = dlpe_pkg::FILE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dlpe_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dlpe_pkg::rsp_t   out_data,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata
);
	localparam int AW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
	localparam int CW = $clog2(FILE_SLOTS + 1);

	dlpe_pkg::state_t state_q, state_d;

	logic [31:0] text_size_q;
	logic [CW-1:0] file_count_q;
	logic [CW-1:0] cur_file_q;
	logic [31:0] cur_col_q, cur_line_q, cur_addr_q;
	logic        preamble_q, err_q;
	logic [2:0]  err_code_q;

	dlpe_pkg::req_t req_q;
	logic [CW-1:0]  idx_q;
	logic [3:0]     cnt_q;

	// shared leb128 shifter
	logic [32:0] sh_q;
	logic        sh_signed_q;

	logic        ov_q;
	dlpe_pkg::rsp_t ov_data_q;

	logic [31:0] ram_rdata;
	logic        ram_we;
	logic [AW-1:0] ram_addr;

	dlpe_ram #(.WIDTH(32), .DEPTH(FILE_SLOTS)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(in_data.file_id), .rdata(ram_rdata)
	);

	// output slot free this cycle
	logic slot_ok;
	assign slot_ok = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_data = ov_data_q;
	assign in_ready = (state_q == dlpe_pkg::S_IDLE) && slot_ok;

	logic acc;
	assign acc = in_valid && in_ready;

	// leb128 byte from the shifter
	logic [32:0] sh_next;
	logic        more;
	logic [7:0]  leb_byte;
	always_comb begin
		sh_next = sh_signed_q ? {{7{sh_q[32]}}, sh_q[32:7]} : {7'd0, sh_q[32:7]};
		if (sh_signed_q) begin
			more = !((sh_next == 33'd0 && !sh_q[6]) || (&sh_next && sh_q[6]));
		end else begin
			more = sh_next != 33'd0;
		end
		leb_byte = {more, sh_q[6:0]};
	end

	// bad-record check on the incoming request
	logic bad_rec;
	assign bad_rec = (in_data.line_number == 32'd0) || (in_data.code_offset > text_size_q)
		|| (in_data.code_offset < cur_addr_q);

	logic [32:0] line_delta;
	assign line_delta = {1'b0, req_q.line_number} - {1'b0, cur_line_q};

	logic        emit;
	logic [7:0]  ebyte;
	logic        elast;
	logic [2:0]  estat;
	logic        ld_sh;
	logic [32:0] ld_val;
	logic        ld_sgn;
	logic        shift_en;

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		ebyte = 8'd0;
		elast = 1'b0;
		estat = dlpe_pkg::ST_OK;
		ld_sh = 1'b0;
		ld_val = 33'd0;
		ld_sgn = 1'b0;
		shift_en = 1'b0;
		ram_we = 1'b0;
		ram_addr = idx_q[AW-1:0];
		unique case (state_q)
			dlpe_pkg::S_IDLE: begin
				ram_addr = file_count_q[AW-1:0];
				if (acc) begin
					if (in_data.opcode == dlpe_pkg::OP_NONE) begin
						state_d = dlpe_pkg::S_IDLE;
					end else if (err_q) begin
						state_d = dlpe_pkg::S_ERR;
					end else begin
						unique case (in_data.opcode)
							dlpe_pkg::OP_DEFINE: begin
								if (file_count_q >= CW'(FILE_SLOTS)) begin
									state_d = dlpe_pkg::S_ERR;
								end else begin
									ram_we = 1'b1;
								end
							end
							dlpe_pkg::OP_LINE: begin
								if (bad_rec) begin
									state_d = dlpe_pkg::S_ERR;
								end else if (file_count_q == '0) begin
									state_d = dlpe_pkg::S_ERR;
								end else begin
									state_d = dlpe_pkg::S_SEARCH_RD;
								end
							end
							default: begin
								if (!preamble_q) begin
									state_d = dlpe_pkg::S_ERR;
								end else if (text_size_q > cur_addr_q) begin
									state_d = dlpe_pkg::S_END_PC_OP;
								end else begin
									state_d = dlpe_pkg::S_END_BYTES;
								end
							end
						endcase
					end
				end
			end
			dlpe_pkg::S_SEARCH_RD: begin
				state_d = dlpe_pkg::S_SEARCH_CMP;
			end
			dlpe_pkg::S_SEARCH_CMP: begin
				if (ram_rdata == req_q.file_id) begin
					state_d = preamble_q ? dlpe_pkg::S_FILE_OP : dlpe_pkg::S_PRE;
				end else if (idx_q + CW'(1) >= file_count_q) begin
					state_d = dlpe_pkg::S_ERR;
				end else begin
					state_d = dlpe_pkg::S_SEARCH_RD;
				end
			end
			dlpe_pkg::S_PRE: begin
				if (slot_ok) begin
					emit = 1'b1;
					ebyte = (cnt_q == 4'd1) ? dlpe_pkg::DW_EXT_LEN :
						(cnt_q == 4'd2) ? dlpe_pkg::DW_SET_ADDR : dlpe_pkg::DW_EXTENDED;
					if (cnt_q == 4'd10) state_d = dlpe_pkg::S_FILE_OP;
				end
			end
			dlpe_pkg::S_FILE_OP: begin
				if (idx_q + CW'(1) != cur_file_q) begin
					if (slot_ok) begin
						emit = 1'b1;
						ebyte = dlpe_pkg::DW_SET_FILE;
						ld_sh = 1'b1;
						ld_val = 33'(idx_q) + 33'd1;
						state_d = dlpe_pkg::S_FILE_VAL;
					end
				end else begin
					state_d = dlpe_pkg::S_COL_OP;
				end
			end
			dlpe_pkg::S_COL_OP: begin
				if (req_q.column != cur_col_q) begin
					if (slot_ok) begin
						emit = 1'b1;
						ebyte = dlpe_pkg::DW_SET_COL;
						ld_sh = 1'b1;
						ld_val = {1'b0, req_q.column};
						state_d = dlpe_pkg::S_COL_VAL;
					end
				end else begin
					state_d = dlpe_pkg::S_LINE_OP;
				end
			end
			dlpe_pkg::S_LINE_OP: begin
				if (req_q.line_number != cur_line_q) begin
					if (slot_ok) begin
						emit = 1'b1;
						ebyte = dlpe_pkg::DW_ADV_LINE;
						ld_sh = 1'b1;
						ld_val = line_delta;
						ld_sgn = 1'b1;
						state_d = dlpe_pkg::S_LINE_VAL;
					end
				end else begin
					state_d = dlpe_pkg::S_PC_OP;
				end
			end
			dlpe_pkg::S_PC_OP: begin
				if (req_q.code_offset != cur_addr_q) begin
					if (slot_ok) begin
						emit = 1'b1;
						ebyte = dlpe_pkg::DW_ADV_PC;
						ld_sh = 1'b1;
						ld_val = {1'b0, req_q.code_offset - cur_addr_q};
						state_d = dlpe_pkg::S_PC_VAL;
					end
				end else begin
					state_d = dlpe_pkg::S_COPY;
				end
			end
			dlpe_pkg::S_END_PC_OP: begin
				if (slot_ok) begin
					emit = 1'b1;
					ebyte = dlpe_pkg::DW_ADV_PC;
					ld_sh = 1'b1;
					ld_val = {1'b0, text_size_q - cur_addr_q};
					state_d = dlpe_pkg::S_END_PC_VAL;
				end
			end
			dlpe_pkg::S_FILE_VAL, dlpe_pkg::S_COL_VAL, dlpe_pkg::S_LINE_VAL,
			dlpe_pkg::S_PC_VAL, dlpe_pkg::S_END_PC_VAL: begin
				if (slot_ok) begin
					emit = 1'b1;
					ebyte = leb_byte;
					shift_en = 1'b1;
					if (!more) begin
						unique case (state_q)
							dlpe_pkg::S_FILE_VAL: state_d = dlpe_pkg::S_COL_OP;
							dlpe_pkg::S_COL_VAL:  state_d = dlpe_pkg::S_LINE_OP;
							dlpe_pkg::S_LINE_VAL: state_d = dlpe_pkg::S_PC_OP;
							dlpe_pkg::S_PC_VAL:   state_d = dlpe_pkg::S_COPY;
							default:              state_d = dlpe_pkg::S_END_BYTES;
						endcase
					end
				end
			end
			dlpe_pkg::S_COPY: begin
				if (slot_ok) begin
					emit = 1'b1;
					ebyte = dlpe_pkg::DW_COPY;
					elast = 1'b1;
					state_d = dlpe_pkg::S_IDLE;
				end
			end
			dlpe_pkg::S_END_BYTES: begin
				if (slot_ok) begin
					emit = 1'b1;
					ebyte = (cnt_q == 4'd0) ? dlpe_pkg::DW_EXTENDED : dlpe_pkg::DW_END_SEQ;
					if (cnt_q == 4'd2) begin
						elast = 1'b1;
						state_d = dlpe_pkg::S_IDLE;
					end
				end
			end
			dlpe_pkg::S_ERR: begin
				if (slot_ok) begin
					emit = 1'b1;
					ebyte = 8'd0;
					elast = 1'b1;
					estat = err_code_q;
					state_d = dlpe_pkg::S_IDLE;
				end
			end
			default: state_d = dlpe_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlpe_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence and error registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_size_q  <= '0;
			file_count_q <= '0;
			cur_file_q   <= CW'(1);
			cur_col_q    <= '0;
			cur_line_q   <= 32'd1;
			cur_addr_q   <= '0;
			preamble_q   <= 1'b0;
			err_q        <= 1'b0;
			err_code_q   <= dlpe_pkg::ST_OK;
			ov_q         <= 1'b0;
			cnt_q        <= '0;
			idx_q        <= '0;
		end else begin
			if (cfg_we) text_size_q <= cfg_wdata;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 4'd1;
			end
			unique case (state_q)
				dlpe_pkg::S_IDLE: begin
					idx_q <= '0;
					if (acc && !err_q && in_data.opcode != dlpe_pkg::OP_NONE) begin
						if (in_data.opcode == dlpe_pkg::OP_DEFINE) begin
							if (file_count_q >= CW'(FILE_SLOTS)) begin
								err_q <= 1'b1;
								err_code_q <= dlpe_pkg::ST_TABLE_FULL;
							end else begin
								file_count_q <= file_count_q + CW'(1);
							end
						end else if (in_data.opcode == dlpe_pkg::OP_LINE) begin
							if (bad_rec) begin
								err_q <= 1'b1;
								err_code_q <= dlpe_pkg::ST_BAD_RECORD;
							end else if (file_count_q == '0) begin
								err_q <= 1'b1;
								err_code_q <= dlpe_pkg::ST_UNKNOWN_FILE;
							end
						end else if (!preamble_q) begin
							err_q <= 1'b1;
							err_code_q <= dlpe_pkg::ST_NO_LINES;
						end
					end
				end
				dlpe_pkg::S_SEARCH_CMP: begin
					if (ram_rdata != req_q.file_id) begin
						if (idx_q + CW'(1) >= file_count_q) begin
							err_q <= 1'b1;
							err_code_q <= dlpe_pkg::ST_UNKNOWN_FILE;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				dlpe_pkg::S_PRE: if (emit) preamble_q <= 1'b1;
				dlpe_pkg::S_FILE_VAL: if (emit && !more) cur_file_q <= idx_q + CW'(1);
				dlpe_pkg::S_COL_VAL: if (emit && !more) cur_col_q <= req_q.column;
				dlpe_pkg::S_LINE_VAL: if (emit && !more) cur_line_q <= req_q.line_number;
				dlpe_pkg::S_PC_VAL: if (emit && !more) cur_addr_q <= req_q.code_offset;
				dlpe_pkg::S_END_BYTES: begin
					if (emit && cnt_q == 4'd2) begin
						cur_file_q <= CW'(1);
						cur_col_q  <= '0;
						cur_line_q <= 32'd1;
						cur_addr_q <= '0;
						preamble_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) req_q <= in_data;
		if (emit) begin
			ov_data_q.out_byte <= ebyte;
			ov_data_q.last     <= elast;
			ov_data_q.status   <= estat;
		end
		if (ld_sh) begin
			sh_q <= ld_val;
			sh_signed_q <= ld_sgn;
		end else if (shift_en) begin
			sh_q <= sh_next;
		end
	end

	// the table never holds more entries than it has slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		file_count_q <= CW'(FILE_SLOTS))
		else $error("file count past table size");

	// once set, the error stays until reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared");

	// no request accepted while a request is in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dlpe_pkg::S_IDLE) |-> !in_ready)
		else $error("ready while busy");

	// an error byte is only sent with the flag set
	a_err_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && estat != dlpe_pkg::ST_OK) |-> err_q)
		else $error("error status without error flag");
endmodule

// ===== rtl/dlpe_ram.sv =====
// generic single-port ram with registered read
module dlpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] addr,
	input  logic [WIDTH-1:0]                 wdata,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
